@@ hdl/hsv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types and constants for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

   localparam int FRACTION_BITS = 8;

   localparam int HUE_W  = 9;
   localparam int IN_W   = 9;
   localparam int CHAN_W = 8;

   localparam int SV_W  = FRACTION_BITS + 1;
   localparam int ONE   = 1 << FRACTION_BITS;
   localparam int CMP_W = (IN_W > SV_W) ? IN_W : SV_W;

   localparam int SECTOR_DEG = 60;
   localparam int HUE_MAX    = 360;
   localparam int K_W        = 6;

   // 60 * ONE and the per-channel products
   localparam int SEC_SCALE = SECTOR_DEG * ONE;
   localparam int A_W       = FRACTION_BITS + 6;
   localparam int SK_W      = SV_W + K_W;
   localparam int W_W       = SV_W + A_W;
   localparam int N_W       = W_W + CHAN_W;

   // den = 60 * ONE^2 = 15 * 2^(2*FB+2); the shifted numerator is at most 3825
   localparam int DEN_SHIFT   = 2 * FRACTION_BITS + 2;
   localparam int DIV_W       = 12;
   localparam int DIV_BY      = 15;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + DIV_BY - 1) / DIV_BY;
   localparam int RECIP_W     = 16;
   localparam int PROD_W      = DIV_W + RECIP_W;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } chan_en_type;

endpackage
`default_nettype wire

@@ hdl/hsv_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_req_if
// Request channel carrying one HSV pixel.
// ----------------------------------------------------------------------------
interface hsv_req_if;
   logic                      valid;
   logic                      ready;
   logic [hsv_pkg::HUE_W-1:0] hue_degrees;
   logic [hsv_pkg::IN_W-1:0]  saturation;
   logic [hsv_pkg::IN_W-1:0]  value_level;

   modport source (output valid, hue_degrees, saturation, value_level, input ready);
   modport sink   (input valid, hue_degrees, saturation, value_level, output ready);
endinterface
`default_nettype wire

@@ hdl/hsv_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_rsp_if
// Response channel carrying one RGB pixel.
// ----------------------------------------------------------------------------
interface hsv_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hsv_pkg::CHAN_W-1:0] red;
   logic [hsv_pkg::CHAN_W-1:0] green;
   logic [hsv_pkg::CHAN_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

@@ hdl/hsv_sector_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_sector_stage
// Input clamp and hue split into 60-degree sector and remainder.
// ----------------------------------------------------------------------------
module hsv_sector_stage (
   input  wire logic                      clock,
   input  wire logic                      enable,
   input  wire logic [hsv_pkg::HUE_W-1:0] hue_degrees,
   input  wire logic [hsv_pkg::IN_W-1:0]  saturation,
   input  wire logic [hsv_pkg::IN_W-1:0]  value_level,
   output hsv_pkg::sector_type            sector,
   output logic [hsv_pkg::K_W-1:0]        rem,
   output logic [hsv_pkg::SV_W-1:0]       sat,
   output logic [hsv_pkg::SV_W-1:0]       val
);

   logic [hsv_pkg::HUE_W-1:0] hue_c;
   logic [hsv_pkg::HUE_W-1:0] base;
   logic [hsv_pkg::CMP_W-1:0] sat_x;
   logic [hsv_pkg::CMP_W-1:0] val_x;

   hsv_pkg::sector_type       sector_in, sector_ff;
   logic [hsv_pkg::K_W-1:0]   rem_in, rem_ff;
   logic [hsv_pkg::SV_W-1:0]  sat_in, sat_ff;
   logic [hsv_pkg::SV_W-1:0]  val_in, val_ff;

   always_comb begin
      hue_c = (hue_degrees > hsv_pkg::HUE_W'(hsv_pkg::HUE_MAX)) ?
              hsv_pkg::HUE_W'(hsv_pkg::HUE_MAX) : hue_degrees;
      sat_x = hsv_pkg::CMP_W'(saturation);
      val_x = hsv_pkg::CMP_W'(value_level);
      sat_in = (sat_x > hsv_pkg::CMP_W'(hsv_pkg::ONE)) ?
               hsv_pkg::SV_W'(hsv_pkg::ONE) : sat_x[hsv_pkg::SV_W-1:0];
      val_in = (val_x > hsv_pkg::CMP_W'(hsv_pkg::ONE)) ?
               hsv_pkg::SV_W'(hsv_pkg::ONE) : val_x[hsv_pkg::SV_W-1:0];

      if (hue_c >= hsv_pkg::HUE_W'(hsv_pkg::HUE_MAX)) begin
         // full circle wraps to the red sector
         sector_in = hsv_pkg::SEC_RED_YEL;
         base      = hsv_pkg::HUE_W'(hsv_pkg::HUE_MAX);
      end else if (hue_c >= hsv_pkg::HUE_W'(5 * hsv_pkg::SECTOR_DEG)) begin
         sector_in = hsv_pkg::SEC_MAG_RED;
         base      = hsv_pkg::HUE_W'(5 * hsv_pkg::SECTOR_DEG);
      end else if (hue_c >= hsv_pkg::HUE_W'(4 * hsv_pkg::SECTOR_DEG)) begin
         sector_in = hsv_pkg::SEC_BLU_MAG;
         base      = hsv_pkg::HUE_W'(4 * hsv_pkg::SECTOR_DEG);
      end else if (hue_c >= hsv_pkg::HUE_W'(3 * hsv_pkg::SECTOR_DEG)) begin
         sector_in = hsv_pkg::SEC_CYN_BLU;
         base      = hsv_pkg::HUE_W'(3 * hsv_pkg::SECTOR_DEG);
      end else if (hue_c >= hsv_pkg::HUE_W'(2 * hsv_pkg::SECTOR_DEG)) begin
         sector_in = hsv_pkg::SEC_GRN_CYN;
         base      = hsv_pkg::HUE_W'(2 * hsv_pkg::SECTOR_DEG);
      end else if (hue_c >= hsv_pkg::HUE_W'(hsv_pkg::SECTOR_DEG)) begin
         sector_in = hsv_pkg::SEC_YEL_GRN;
         base      = hsv_pkg::HUE_W'(hsv_pkg::SECTOR_DEG);
      end else begin
         sector_in = hsv_pkg::SEC_RED_YEL;
         base      = '0;
      end
      rem_in = hsv_pkg::K_W'(hue_c - base);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sector_ff <= sector_in;
         rem_ff    <= rem_in;
         sat_ff    <= sat_in;
         val_ff    <= val_in;
      end
   end

   assign sector = sector_ff;
   assign rem    = rem_ff;
   assign sat    = sat_ff;
   assign val    = val_ff;

endmodule
`default_nettype wire

@@ hdl/hsv_chan_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_chan_unit
// One color term: floor(255 * v * (60*ONE - s*k) / (60*ONE*ONE)).
// Stage 2 forms 60*ONE - s*k, stage 3 multiplies by v, stage 4 scales by 255
// and drops the power-of-two part of the divisor; the divide by 15 is a
// reciprocal multiply on the stage 4 register.
// ----------------------------------------------------------------------------
module hsv_chan_unit (
   input  wire logic                       clock,
   input  wire hsv_pkg::chan_en_type       en,
   input  wire logic [hsv_pkg::SV_W-1:0]   sat,
   input  wire logic [hsv_pkg::SV_W-1:0]   val,
   input  wire logic [hsv_pkg::K_W-1:0]    k,
   output logic [hsv_pkg::CHAN_W-1:0]      chan
);

   logic [hsv_pkg::SK_W-1:0]   sk;
   logic [hsv_pkg::A_W-1:0]    a_in, a_ff;
   logic [hsv_pkg::SV_W-1:0]   v2_ff;
   logic [hsv_pkg::W_W-1:0]    w_in, w_ff;
   logic [hsv_pkg::N_W-1:0]    n;
   logic [hsv_pkg::DIV_W-1:0]  x_in, x_ff;
   logic [hsv_pkg::PROD_W-1:0] prod;

   always_comb begin
      sk   = hsv_pkg::SK_W'(sat) * hsv_pkg::SK_W'(k);
      a_in = hsv_pkg::A_W'(hsv_pkg::SEC_SCALE) - sk[hsv_pkg::A_W-1:0];
      w_in = hsv_pkg::W_W'(v2_ff) * hsv_pkg::W_W'(a_ff);
      n    = (hsv_pkg::N_W'(w_ff) << hsv_pkg::CHAN_W) - hsv_pkg::N_W'(w_ff);
      x_in = n[hsv_pkg::DEN_SHIFT + hsv_pkg::DIV_W - 1:hsv_pkg::DEN_SHIFT];
      prod = hsv_pkg::PROD_W'(x_ff) * hsv_pkg::PROD_W'(hsv_pkg::RECIP);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         a_ff  <= a_in;
         v2_ff <= val;
      end
      if (en.s3) begin
         w_ff <= w_in;
      end
      if (en.s4) begin
         x_ff <= x_in;
      end
   end

   assign chan = prod[hsv_pkg::RECIP_SHIFT + hsv_pkg::CHAN_W - 1:hsv_pkg::RECIP_SHIFT];

endmodule
`default_nettype wire

@@ hdl/hsv_to_rgb_converter_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to 8-bit RGB pixel converter, five register stages.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock while the response is not stalled; each stage advances when its successor
// has room, so a stalled response only holds the stages behind it.
// Reset: synchronous, clears the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
   input  wire logic clock,
   input  wire logic reset,
   hsv_req_if.sink   req_chan,
   hsv_rsp_if.source rsp_chan
);

   logic en1, en2, en3, en4, en5;
   logic vld1_in, vld1_ff, vld2_in, vld2_ff, vld3_in, vld3_ff;
   logic vld4_in, vld4_ff, vld5_in, vld5_ff;

   hsv_pkg::sector_type            sec1;
   hsv_pkg::sector_type            sec2_ff, sec3_ff, sec4_ff, sec5_ff;
   logic [hsv_pkg::K_W-1:0]        rem1;
   logic [hsv_pkg::K_W-1:0]        k_t;
   logic [hsv_pkg::SV_W-1:0]       sat1, val1;
   logic [hsv_pkg::CHAN_W-1:0]     c_v, c_p, c_q, c_t;
   logic [hsv_pkg::CHAN_W-1:0]     red_in, red_ff, green_in, green_ff, blue_in, blue_ff;
   hsv_pkg::chan_en_type           chan_en;

   // stall chain, from the output back
   always_comb begin
      en5 = !vld5_ff || rsp_chan.ready;
      en4 = !vld4_ff || en5;
      en3 = !vld3_ff || en4;
      en2 = !vld2_ff || en3;
      en1 = !vld1_ff || en2;
      vld1_in = en1 ? req_chan.valid : vld1_ff;
      vld2_in = en2 ? vld1_ff : vld2_ff;
      vld3_in = en3 ? vld2_ff : vld3_ff;
      vld4_in = en4 ? vld3_ff : vld4_ff;
      vld5_in = en5 ? vld4_ff : vld5_ff;
      chan_en.s2 = en2;
      chan_en.s3 = en3;
      chan_en.s4 = en4;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         vld1_ff <= vld1_in;
         vld2_ff <= vld2_in;
         vld3_ff <= vld3_in;
         vld4_ff <= vld4_in;
         vld5_ff <= vld5_in;
      end
   end

   hsv_sector_stage u_sector (
      .clock       (clock),
      .enable      (en1),
      .hue_degrees (req_chan.hue_degrees),
      .saturation  (req_chan.saturation),
      .value_level (req_chan.value_level),
      .sector      (sec1),
      .rem         (rem1),
      .sat         (sat1),
      .val         (val1)
   );

   assign k_t = hsv_pkg::K_W'(hsv_pkg::SECTOR_DEG) - rem1;

   hsv_chan_unit u_chan_v (
      .clock (clock), .en (chan_en), .sat (sat1), .val (val1),
      .k ('0), .chan (c_v)
   );

   hsv_chan_unit u_chan_p (
      .clock (clock), .en (chan_en), .sat (sat1), .val (val1),
      .k (hsv_pkg::K_W'(hsv_pkg::SECTOR_DEG)), .chan (c_p)
   );

   hsv_chan_unit u_chan_q (
      .clock (clock), .en (chan_en), .sat (sat1), .val (val1),
      .k (rem1), .chan (c_q)
   );

   hsv_chan_unit u_chan_t (
      .clock (clock), .en (chan_en), .sat (sat1), .val (val1),
      .k (k_t), .chan (c_t)
   );

   always_comb begin
      case (sec4_ff)
         hsv_pkg::SEC_YEL_GRN: begin
            red_in = c_q; green_in = c_v; blue_in = c_p;
         end
         hsv_pkg::SEC_GRN_CYN: begin
            red_in = c_p; green_in = c_v; blue_in = c_t;
         end
         hsv_pkg::SEC_CYN_BLU: begin
            red_in = c_p; green_in = c_q; blue_in = c_v;
         end
         hsv_pkg::SEC_BLU_MAG: begin
            red_in = c_t; green_in = c_p; blue_in = c_v;
         end
         hsv_pkg::SEC_MAG_RED: begin
            red_in = c_v; green_in = c_p; blue_in = c_q;
         end
         default: begin
            red_in = c_v; green_in = c_t; blue_in = c_p;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         sec2_ff <= sec1;
      end
      if (en3) begin
         sec3_ff <= sec2_ff;
      end
      if (en4) begin
         sec4_ff <= sec3_ff;
      end
      if (en5) begin
         sec5_ff  <= sec4_ff;
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign req_chan.ready = en1;
   assign rsp_chan.valid = vld5_ff;
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld1_ff)
      else $error("accepted request did not enter stage 1");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (vld1_ff && !en2) |=> (vld1_ff && $stable(sec1) && $stable(rem1)))
      else $error("stage 1 changed while stalled");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("request side blocked without an output stall");

   a_red_sector_order: assert property (@(posedge clock) disable iff (reset)
      (vld5_ff && sec5_ff == hsv_pkg::SEC_RED_YEL) |->
         (rsp_chan.red >= rsp_chan.green && rsp_chan.green >= rsp_chan.blue))
      else $error("channel order wrong in red sector");

endmodule
`default_nettype wire
